/* rtl/core/pbrd_pkg.sv */
package pbrd_pkg;

	// Fixed-point averaging coefficients, 16-bit fractions.
	localparam int COEF_BITS = 16;
	localparam int KT_BITS = 17;
	localparam logic [COEF_BITS-1:0] K_DC_OLD = 16'd63570;
	localparam logic [COEF_BITS-1:0] K_DC_NEW = 16'd1966;
	localparam logic [COEF_BITS-1:0] K_ENV_OLD = 16'd62259;
	localparam logic [COEF_BITS-1:0] K_ENV_NEW = 16'd3277;
	localparam logic [KT_BITS-1:0] K_THRESH = 17'd78643;
	localparam logic [COEF_BITS-1:0] COEF_HALF = 16'h8000;

	// Field widths fixed by the interface.
	localparam int TIME_BITS = 32;
	localparam int INTERVAL_BITS = 16;
	localparam int RATE_BITS = 16;

	// Rate division: (60000 * 256 + d/2) / d in Q8.8.
	localparam int DIV_N_BITS = 24;
	localparam int DIV_D_BITS = 16;
	localparam logic [DIV_N_BITS-1:0] RATE_NUM = 24'd15360000;

	// Configuration port.
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 32;
	localparam int NO_FINGER_RESET = 8000;
	localparam int THR_FLOOR_RESET = 150;
	localparam int MIN_INT_RESET = 300;
	localparam int MAX_INT_RESET = 2000;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_NO_FINGER = 8'd0,
		REG_THR_FLOOR = 8'd1,
		REG_MIN_INT   = 8'd2,
		REG_MAX_INT   = 8'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_BASE_A,
		B_BASE_B,
		B_MAG,
		B_ENV_A,
		B_ENV_B,
		B_THR,
		B_CMP,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

/* rtl/core/pbrd_in_if.sv */
interface pbrd_in_if #(
	parameter int SAMPLE_BITS = 18
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] ir_sample;
	logic [31:0]            time_ms;

	modport source (output valid, ir_sample, time_ms, input ready);
	modport sink (input valid, ir_sample, time_ms, output ready);
endinterface

/* rtl/core/pbrd_out_if.sv */
interface pbrd_out_if #(
	parameter int SAMPLE_BITS = 18
) ();
	logic                          valid;
	logic                          ready;
	logic                          finger_present;
	logic signed [SAMPLE_BITS:0]   ac_value;
	logic [SAMPLE_BITS-1:0]        threshold_value;
	logic                          beat_edge;
	logic                          rate_updated;
	logic [15:0]                   beats_per_min;

	modport source (output valid, finger_present, ac_value, threshold_value, beat_edge,
		rate_updated, beats_per_min, input ready);
	modport sink (input valid, finger_present, ac_value, threshold_value, beat_edge,
		rate_updated, beats_per_min, output ready);
endinterface

/* rtl/core/pbrd_cfg_if.sv */
interface pbrd_cfg_if ();
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/pbrd_fifo.sv */
module pbrd_fifo
	import pbrd_pkg::*;
#(
	parameter int WIDTH = 51,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/pbrd_front.sv */
module pbrd_front
	import pbrd_pkg::*;
#(
	parameter int SAMPLE_BITS = 18
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pbrd_in_if.sink                         samples,
	pbrd_cfg_if.sink                        cfg,
	output logic                            push,
	input  logic                            q_full,
	output logic [SAMPLE_BITS+TIME_BITS:0]  push_data,
	output logic [SAMPLE_BITS-1:0]          threshold_floor,
	output logic [INTERVAL_BITS-1:0]        min_interval_ms,
	output logic [INTERVAL_BITS-1:0]        max_interval_ms
);

	logic [SAMPLE_BITS-1:0] no_finger_q;
	logic [SAMPLE_BITS-1:0] floor_q;
	logic [INTERVAL_BITS-1:0] min_int_q;
	logic [INTERVAL_BITS-1:0] max_int_q;
	logic finger;

	assign threshold_floor = floor_q;
	assign min_interval_ms = min_int_q;
	assign max_interval_ms = max_int_q;

	// Classify at the door: a sample under the no-finger level clears the back end.
	assign finger        = (samples.ir_sample >= no_finger_q);
	assign samples.ready = !q_full;
	assign push          = samples.valid && !q_full;
	assign push_data     = {finger, samples.time_ms, samples.ir_sample};
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_finger_q <= SAMPLE_BITS'(NO_FINGER_RESET);
			floor_q     <= SAMPLE_BITS'(THR_FLOOR_RESET);
			min_int_q   <= INTERVAL_BITS'(MIN_INT_RESET);
			max_int_q   <= INTERVAL_BITS'(MAX_INT_RESET);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_NO_FINGER: no_finger_q <= cfg.data[SAMPLE_BITS-1:0];
				REG_THR_FLOOR: floor_q     <= cfg.data[SAMPLE_BITS-1:0];
				REG_MIN_INT:   min_int_q   <= cfg.data[INTERVAL_BITS-1:0];
				REG_MAX_INT:   max_int_q   <= cfg.data[INTERVAL_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/pbrd_div.sv */
module pbrd_div
	import pbrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIV_N_BITS-1:0] dividend,
	input  logic [DIV_D_BITS-1:0] divisor,
	output logic                  done,
	output logic [DIV_N_BITS-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_N_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIV_D_BITS-1:0] rem_q;
	logic [DIV_D_BITS-1:0] dsr_q;
	logic [DIV_N_BITS-1:0] quo_q;
	logic [DIV_D_BITS:0]   rem_sh;
	logic                  ge;
	logic [DIV_D_BITS:0]   rem_nx;

	// Restoring division, one quotient bit per cycle.
	assign rem_sh   = {rem_q, quo_q[DIV_N_BITS-1]};
	assign ge       = (rem_sh >= {1'b0, dsr_q});
	assign rem_nx   = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_N_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx[DIV_D_BITS-1:0];
			quo_q <= {quo_q[DIV_N_BITS-2:0], ge};
		end
	end

endmodule

/* rtl/core/pbrd_back.sv */
module pbrd_back
	import pbrd_pkg::*;
#(
	parameter int SAMPLE_BITS = 18,
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	output logic                            q_pop,
	input  logic [SAMPLE_BITS+TIME_BITS:0]  q_data,
	input  logic [SAMPLE_BITS-1:0]          threshold_floor,
	input  logic [INTERVAL_BITS-1:0]        min_interval_ms,
	input  logic [INTERVAL_BITS-1:0]        max_interval_ms,
	pbrd_out_if.source                      results
);

	localparam int W   = SAMPLE_BITS + FRAC_BITS;
	localparam int P_W = W + KT_BITS;
	localparam int S_W = P_W + 1;
	localparam int A_W = SAMPLE_BITS + 1;
	localparam int B_W = RATE_BITS + 2;

	back_state_t state_q, state_d;

	// Beat state.
	logic [W-1:0]          baseline_q;
	logic [W-1:0]          envelope_q;
	logic                  was_above_q;
	logic [TIME_BITS-1:0]  last_beat_q;
	logic [RATE_BITS-1:0]  rate_q;

	// Item in flight.
	logic [SAMPLE_BITS-1:0] x_q;
	logic [TIME_BITS-1:0]   now_q;
	logic                   fing_q;
	logic [P_W-1:0]         prod_q;
	logic                   neg_q;
	logic [W-1:0]           mag_q;
	logic [W-1:0]           th_q;
	logic                   edge_q;
	logic                   upd_q;

	// Output register.
	logic                   out_valid_q;
	logic                   out_fing_q;
	logic [A_W-1:0]         out_ac_q;
	logic [SAMPLE_BITS-1:0] out_th_q;
	logic                   out_edge_q;
	logic                   out_upd_q;
	logic [RATE_BITS-1:0]   out_rate_q;

	logic                   head_finger;
	logic [W-1:0]           xq;
	logic [W-1:0]           base_sel;
	logic [W-1:0]           mul_a;
	logic [KT_BITS-1:0]     mul_b;
	logic [P_W-1:0]         prod_d;
	logic [W-1:0]           mix_a;
	logic [COEF_BITS-1:0]   mix_b;
	logic [S_W-1:0]         sum_d;
	logic [W-1:0]           avg_d;
	logic                   neg_d;
	logic [W-1:0]           mag_d;
	logic [P_W-1:0]         th_sum;
	logic [W:0]             th_raw;
	logic [W-1:0]           th_sat;
	logic [W-1:0]           floor_w;
	logic [W-1:0]           th_d;
	logic                   above_d;
	logic                   edge_d;
	logic [TIME_BITS-1:0]   delta;
	logic                   interval_ok;
	logic                   div_start;
	logic                   div_done;
	logic [DIV_N_BITS-1:0]  div_dividend;
	logic [DIV_N_BITS-1:0]  div_quo;
	logic [RATE_BITS-1:0]   inst_rate;
	logic [B_W-1:0]         blend_sum;
	logic [RATE_BITS-1:0]   rate_next;
	logic [A_W-1:0]         ac_mag;
	logic [A_W-1:0]         ac_d;
	logic                   out_load;

	assign head_finger = q_data[SAMPLE_BITS+TIME_BITS];
	assign xq          = {x_q, {FRAC_BITS{1'b0}}};
	assign base_sel    = (baseline_q == '0) ? xq : baseline_q;

	// One shared multiplier for the "old" terms and the threshold gain.
	always_comb begin
		mul_a = envelope_q;
		mul_b = KT_BITS'(K_ENV_OLD);
		mix_a = mag_q;
		mix_b = K_ENV_NEW;
		case (state_q)
			B_BASE_A: begin
				mul_a = base_sel;
				mul_b = KT_BITS'(K_DC_OLD);
			end
			B_BASE_B: begin
				mix_a = xq;
				mix_b = K_DC_NEW;
			end
			B_THR: begin
				mul_b = K_THRESH;
			end
			default: ;
		endcase
	end

	assign prod_d = P_W'(mul_a) * P_W'(mul_b);
	assign sum_d  = S_W'(prod_q) + S_W'(mix_a) * S_W'(mix_b) + S_W'(COEF_HALF);
	assign avg_d  = sum_d[COEF_BITS +: W];

	assign neg_d = (xq < baseline_q);
	assign mag_d = neg_d ? (baseline_q - xq) : (xq - baseline_q);

	// The threshold product is rounded like the averages before it drops its
	// coefficient fraction.
	assign th_sum  = prod_q + P_W'(COEF_HALF);
	assign th_raw  = th_sum[P_W-1:COEF_BITS];
	assign th_sat  = th_raw[W] ? {W{1'b1}} : th_raw[W-1:0];
	assign floor_w = {threshold_floor, {FRAC_BITS{1'b0}}};
	assign th_d    = (th_sat < floor_w) ? floor_w : th_sat;
	assign above_d = !neg_q && (mag_q > th_d);
	assign edge_d  = above_d && !was_above_q;

	assign delta       = now_q - last_beat_q;
	assign interval_ok = (last_beat_q != '0) && (delta > TIME_BITS'(min_interval_ms))
		&& (delta < TIME_BITS'(max_interval_ms)) && (delta != '0);
	assign div_dividend = RATE_NUM + DIV_N_BITS'(delta[DIV_D_BITS-1:1]);

	assign inst_rate = (div_quo[DIV_N_BITS-1:RATE_BITS] != '0) ? {RATE_BITS{1'b1}}
		: div_quo[RATE_BITS-1:0];
	assign blend_sum = B_W'({rate_q, 1'b0}) + B_W'(rate_q) + B_W'(inst_rate) + B_W'(2);
	assign rate_next = (rate_q == '0) ? inst_rate : blend_sum[B_W-1:2];

	assign ac_mag = {1'b0, mag_q[W-1:FRAC_BITS]};
	assign ac_d   = neg_q ? (~ac_mag + A_W'(1)) : ac_mag;

	pbrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (delta[DIV_D_BITS-1:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					state_d = head_finger ? B_BASE_A : B_DONE;
				end
			end
			B_BASE_A: state_d = B_BASE_B;
			B_BASE_B: state_d = B_MAG;
			B_MAG:    state_d = B_ENV_A;
			B_ENV_A:  state_d = B_ENV_B;
			B_ENV_B:  state_d = B_THR;
			B_THR:    state_d = B_CMP;
			B_CMP:    state_d = (edge_d && interval_ok) ? B_DIV : B_DONE;
			B_DIV: begin
				if (div_done) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (!out_valid_q || results.ready) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			B_IDLE: q_pop     = !q_empty;
			B_CMP:  div_start = edge_d && interval_ok;
			B_DONE: out_load  = !out_valid_q || results.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			baseline_q  <= '0;
			envelope_q  <= '0;
			was_above_q <= 1'b0;
			last_beat_q <= '0;
			rate_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && !head_finger) begin
				baseline_q  <= '0;
				envelope_q  <= '0;
				was_above_q <= 1'b0;
				last_beat_q <= '0;
				rate_q      <= '0;
			end
			if (state_q == B_BASE_B) begin
				baseline_q <= avg_d;
			end
			if (state_q == B_ENV_B) begin
				envelope_q <= avg_d;
			end
			if (state_q == B_CMP) begin
				was_above_q <= above_d;
				if (edge_d) begin
					last_beat_q <= now_q;
				end
			end
			if (state_q == B_DIV && div_done) begin
				rate_q <= rate_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			x_q    <= q_data[SAMPLE_BITS-1:0];
			now_q  <= q_data[SAMPLE_BITS +: TIME_BITS];
			fing_q <= head_finger;
			edge_q <= 1'b0;
			upd_q  <= 1'b0;
			if (!head_finger) begin
				neg_q <= 1'b0;
				mag_q <= '0;
				th_q  <= '0;
			end
		end
		if (state_q == B_BASE_A || state_q == B_ENV_A || state_q == B_THR) begin
			prod_q <= prod_d;
		end
		if (state_q == B_MAG) begin
			neg_q <= neg_d;
			mag_q <= mag_d;
		end
		if (state_q == B_CMP) begin
			th_q   <= th_d;
			edge_q <= edge_d;
		end
		if (state_q == B_DIV && div_done) begin
			upd_q <= 1'b1;
		end
		if (out_load) begin
			out_fing_q <= fing_q;
			out_ac_q   <= ac_d;
			out_th_q   <= th_q[W-1:FRAC_BITS];
			out_edge_q <= edge_q;
			out_upd_q  <= upd_q;
			out_rate_q <= rate_q;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.finger_present  = out_fing_q;
	assign results.ac_value        = out_ac_q;
	assign results.threshold_value = out_th_q;
	assign results.beat_edge       = out_edge_q;
	assign results.rate_updated    = out_upd_q;
	assign results.beats_per_min   = out_rate_q;

endmodule

/* rtl/core/pulse_beat_rate_detector.sv */
// Pulse beat rate detector for an optical finger sensor.
// Input channel "samples" carries one infrared sample and its millisecond time
// stamp per transfer; output channel "results" returns exactly one result per
// sample, in order: finger flag, AC value, threshold, beat edge, rate update
// flag and the smoothed rate in Q8.8 beats per minute.
// Channel "cfg" writes the no-finger level, threshold floor and the beat
// interval window by register index; it is always ready.
// A result is offered once its sample has gone through the back-end states
// B_BASE_A to B_CMP; when a beat with a valid interval updates the rate, it
// also waits in B_DIV for the rate from a restoring divider that retires one
// quotient bit per cycle. A no-finger sample goes from B_IDLE to B_DONE.
// The back end handles one item at a time and pops no new sample until the
// current one has left B_DONE, so a two-entry queue lets the front keep
// taking samples while the back end is busy.
// Reset clears all beat state and loads the register defaults.
// When the receiver stalls, the finished result waits in the output register,
// the back end finishes the next item and then holds, and the input channel
// drops ready once the queue is full.
module pulse_beat_rate_detector
	import pbrd_pkg::*;
#(
	parameter int SAMPLE_BITS = 18,
	parameter int FRAC_BITS = 16,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	pbrd_in_if.sink      samples,
	pbrd_out_if.source   results,
	pbrd_cfg_if.sink     cfg
);

	// Queue entry: finger flag, time stamp, sample.
	localparam int ENTRY_W = SAMPLE_BITS + TIME_BITS + 1;

	logic                     push;
	logic                     q_full;
	logic                     q_empty;
	logic                     q_pop;
	logic [ENTRY_W-1:0]       push_data;
	logic [ENTRY_W-1:0]       q_head;
	logic [SAMPLE_BITS-1:0]   threshold_floor;
	logic [INTERVAL_BITS-1:0] min_interval_ms;
	logic [INTERVAL_BITS-1:0] max_interval_ms;

	// The front end holds the configuration and tags each sample with whether
	// a finger is present, so the back end needs only the flag, not the no-finger level.
	pbrd_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.samples         (samples),
		.cfg             (cfg),
		.push            (push),
		.q_full          (q_full),
		.push_data       (push_data),
		.threshold_floor (threshold_floor),
		.min_interval_ms (min_interval_ms),
		.max_interval_ms (max_interval_ms)
	);

	pbrd_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// The back end runs the baseline and envelope averages and the threshold gain
	// through one shared multiplier, detects the rising crossing and, on a beat
	// with an interval inside the window, divides to get the instantaneous rate.
	pbrd_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.q_data          (q_head),
		.threshold_floor (threshold_floor),
		.min_interval_ms (min_interval_ms),
		.max_interval_ms (max_interval_ms),
		.results         (results)
	);

endmodule
